// ----- rtl/sbs_pkg.sv -----
// Shared constants and types of the sort-then-binary-search core.
// Used by every module under rtl; depends on nothing.
package sbs_pkg;

	localparam int STORE_DEPTH = 128;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int POS_W       = 7;
	localparam int PRB_W       = 4;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [IDX_W-1:0]         idx_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic  load;
		logic  rot;
		data_t din;
	} cell_ctl_t;

endpackage

// ----- rtl/sort_then_binary_search_core.sv -----
// Top level of the sort-then-binary-search core: a chain of insertion cells
// closed into a ring, plus the search controller. Depends on sbs_pkg,
// sbs_cell and sbs_ctrl.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid/in_ready: element_value,          | into core
//          | search_key, is_last                        |
//  out     | out_valid/out_ready: found, position,      | out of core
//          | probe_count, overflow                      |
//
// Elements are taken one per cycle; the chain sorts as it loads.
// After the last item the ring rotates one place a cycle and each probe waits
// for its entry to reach the head cell.
// in_ready is low from the last item until the result is written to the
// output register; a stalled result holds only that final write.
// Reset clears count, overflow and control; the element cells are not cleared.
module sort_then_binary_search_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sbs_pkg::data_t            element_value,
	input  sbs_pkg::data_t            search_key,
	input  logic                      is_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [sbs_pkg::POS_W-1:0] position,
	output logic [sbs_pkg::PRB_W-1:0] probe_count,
	output logic                      overflow
);
	import sbs_pkg::*;

	cell_ctl_t cell_ctl;
	cnt_t      cnt;
	data_t     vals [STORE_DEPTH];
	logic      gts  [STORE_DEPTH];

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic  occupied;
		logic  is_tail;
		logic  prev_gt;
		data_t prev_val;
		data_t next_val;

		assign occupied = CNT_W'(i) < cnt;
		assign is_tail  = CNT_W'(i) == cnt;

		if (i == 0) begin : g_first
			assign prev_gt  = 1'b0;
			assign prev_val = '0;
		end else begin : g_rest
			assign prev_gt  = gts[i-1];
			assign prev_val = vals[i-1];
		end

		if (i == STORE_DEPTH - 1) begin : g_wrap
			assign next_val = vals[0];
		end else begin : g_mid
			assign next_val = vals[i+1];
		end

		sbs_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.occupied (occupied),
			.is_tail  (is_tail),
			.prev_gt  (prev_gt),
			.prev_val (prev_val),
			.next_val (next_val),
			.val      (vals[i]),
			.gt       (gts[i])
		);
	end

	sbs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element_value (element_value),
		.search_key    (search_key),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.position      (position),
		.probe_count   (probe_count),
		.overflow      (overflow),
		.head_val      (vals[0]),
		.cell_ctl      (cell_ctl),
		.cnt           (cnt)
	);

endmodule

// ----- rtl/sbs_cell.sv -----
// One cell of the sorting chain: holds one element, inserts in order on load
// and passes its value to the neighbour below when the ring rotates.
// Depends on sbs_pkg.
module sbs_cell (
	input  logic              clk,
	input  sbs_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic              is_tail,
	input  logic              prev_gt,
	input  sbs_pkg::data_t    prev_val,
	input  sbs_pkg::data_t    next_val,
	output sbs_pkg::data_t    val,
	output logic              gt
);
	import sbs_pkg::*;

	data_t val_q;

	assign gt  = occupied && (val_q > ctl.din);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			val_q <= next_val;
		end else if (ctl.load && (gt || is_tail)) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else begin
				val_q <= ctl.din;
			end
		end
	end

endmodule

// ----- rtl/sbs_ctrl.sv -----
// Load counter, overflow flag, binary search sequencer and result register.
// Watches the head cell of the rotating chain. Depends on sbs_pkg.
module sbs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sbs_pkg::data_t            element_value,
	input  sbs_pkg::data_t            search_key,
	input  logic                      is_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [sbs_pkg::POS_W-1:0] position,
	output logic [sbs_pkg::PRB_W-1:0] probe_count,
	output logic                      overflow,
	input  sbs_pkg::data_t            head_val,
	output sbs_pkg::cell_ctl_t        cell_ctl,
	output sbs_pkg::cnt_t             cnt
);
	import sbs_pkg::*;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	cnt_t             cnt_q;
	logic             ovf_q;
	data_t            key_q;
	cnt_t             lo_q;
	cnt_t             hp1_q;
	idx_t             rot_q;
	logic [PRB_W-1:0] prb_q;
	logic             hit_q;
	idx_t             pos_q;
	logic             out_valid_q;
	logic             found_q;
	logic [POS_W-1:0] position_q;
	logic [PRB_W-1:0] probe_q;
	logic             overflow_q;

	logic             in_acc;
	logic             has_room;
	logic [CNT_W:0]   mid_sum;
	cnt_t             mid;
	logic             open_range;
	logic             probe_now;
	logic             out_free;
	idx_t             rot_next;

	assign in_ready   = (state_q == ST_LOAD);
	assign in_acc     = in_valid && in_ready;
	assign has_room   = cnt_q < CNT_W'(STORE_DEPTH);
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hp1_q} - 1'b1;
	assign mid        = mid_sum[CNT_W:1];
	assign open_range = lo_q < hp1_q;
	assign probe_now  = (state_q == ST_SRCH) && open_range && (rot_q == mid[IDX_W-1:0]);
	assign out_free   = !out_valid_q || out_ready;
	assign rot_next   = (rot_q == IDX_W'(STORE_DEPTH - 1)) ? '0 : rot_q + 1'b1;

	assign cell_ctl.load = in_acc && has_room;
	assign cell_ctl.rot  = (state_q == ST_SRCH);
	assign cell_ctl.din  = element_value;
	assign cnt           = cnt_q;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign position    = position_q;
	assign probe_count = probe_q;
	assign overflow    = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			lo_q        <= '0;
			hp1_q       <= '0;
			rot_q       <= '0;
			prb_q       <= '0;
			hit_q       <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (is_last) begin
							lo_q    <= '0;
							hp1_q   <= has_room ? cnt_q + 1'b1 : cnt_q;
							rot_q   <= '0;
							prb_q   <= '0;
							hit_q   <= 1'b0;
							pos_q   <= '0;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					rot_q <= rot_next;
					if (!open_range) begin
						state_q <= ST_DONE;
					end else if (probe_now) begin
						prb_q <= prb_q + 1'b1;
						if (head_val == key_q) begin
							hit_q   <= 1'b1;
							pos_q   <= mid[IDX_W-1:0];
							state_q <= ST_DONE;
						end else if (head_val < key_q) begin
							lo_q <= mid + 1'b1;
						end else begin
							hp1_q <= mid;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && is_last) begin
			key_q <= search_key;
		end
		if ((state_q == ST_DONE) && out_free) begin
			found_q    <= hit_q;
			position_q <= POS_W'(pos_q);
			probe_q    <= prb_q;
			overflow_q <= ovf_q;
		end
	end

endmodule

// ----- rtl/sbs_checker.sv -----
// Port-level checks of the sort-then-binary-search core, bound to the top.
// Depends on sbs_pkg and sort_then_binary_search_core.
module sbs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      is_last,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      found,
	input logic [sbs_pkg::POS_W-1:0] position,
	input logic [sbs_pkg::PRB_W-1:0] probe_count,
	input logic                      overflow
);
	import sbs_pkg::*;

	localparam int MAX_PROBES = $clog2(STORE_DEPTH + 1);

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position)
			&& $stable(probe_count) && $stable(overflow))
		else $error("result changed while stalled");

	// search runs after the last item, so the input closes
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last |=> !in_ready)
		else $error("input open right after last item");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("position set on a miss");

	a_hit_probed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> probe_count != '0)
		else $error("hit without a probe");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (MAX_PROBES >= (1 << PRB_W)) || (probe_count <= PRB_W'(MAX_PROBES)))
		else $error("too many probes");

endmodule

bind sort_then_binary_search_core sbs_checker u_sbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.is_last     (is_last),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.position    (position),
	.probe_count (probe_count),
	.overflow    (overflow)
);
